### design/dqc_pkg.sv
// ----------------------------------------------------------------------------
// dqc_pkg
// Shared types and constants for the double-ended queue with cursor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dqc_pkg;

  // Default capacity and word width
  localparam int DQC_CAPACITY = 16;
  localparam int WORD_W       = 32;
  localparam int OP_W         = 3;
  localparam int STAT_W       = 2;
  localparam int DQC_CNT_W    = $clog2(DQC_CAPACITY + 1);
  localparam int DQC_POS_W    = $clog2(DQC_CAPACITY);

  // Operation codes carried by an input beat
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_L  = 3'd0,
    OP_PUSH_R  = 3'd1,
    OP_POP_L   = 3'd2,
    OP_POP_R   = 3'd3,
    OP_CUR_L   = 3'd4,
    OP_CUR_R   = 3'd5,
    OP_READ    = 3'd6,
    OP_WRITE   = 3'd7
  } op_t;

  // Status codes of a result beat
  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_AT_END = 2'd3
  } status_t;

  // What every cell of the row does this cycle
  typedef enum logic [1:0] {
    CK_HOLD  = 2'd0,
    CK_SHR   = 2'd1,   // take left neighbour, cell 0 takes the new word
    CK_SHL   = 2'd2,   // take right neighbour
    CK_WRITE = 2'd3    // addressed cell takes the new word
  } cell_kind_t;

  typedef struct packed {
    cell_kind_t               kind;
    logic signed [WORD_W-1:0] value;
  } cell_ctl_t;

  // Top-level sequencer
  typedef enum logic {
    S_IDLE = 1'b0,
    S_HOLD = 1'b1
  } state_t;

endpackage

`default_nettype wire

### design/dqc_in_if.sv
// ----------------------------------------------------------------------------
// dqc_in_if
// Operation channel: valid/ready with operation code and word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dqc_in_if
  import dqc_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

`default_nettype wire

### design/dqc_out_if.sv
// ----------------------------------------------------------------------------
// dqc_out_if
// Result channel: valid/ready with outcome and end/cursor words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dqc_out_if
  import dqc_pkg::*;
#(
  parameter int CNT_W = DQC_CNT_W
);
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] result_value;
  logic [STAT_W-1:0]        status;
  logic [CNT_W-1:0]         count;
  logic                     is_empty;
  logic signed [WORD_W-1:0] left_word;
  logic signed [WORD_W-1:0] right_word;
  logic signed [WORD_W-1:0] cursor_word;

  modport source (output valid, output result_value, output status, output count,
                  output is_empty, output left_word, output right_word,
                  output cursor_word, input ready);
  modport sink   (input valid, input result_value, input status, input count,
                  input is_empty, input left_word, input right_word,
                  input cursor_word, output ready);
endinterface

`default_nettype wire

### design/dqc_cell.sv
// ----------------------------------------------------------------------------
// dqc_cell
// One word slot of the queue row; shifts with its neighbours or is written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dqc_cell
  import dqc_pkg::*;
#(
  parameter int             POS_W = DQC_POS_W,
  parameter logic [POS_W-1:0] IDX = '0
) (
  input  wire logic                     clk,
  input  wire cell_ctl_t                ctl,
  input  wire logic [POS_W-1:0]         wr_idx,
  input  wire logic signed [WORD_W-1:0] left_in,
  input  wire logic signed [WORD_W-1:0] right_in,
  output      logic signed [WORD_W-1:0] word_o
);

  logic signed [WORD_W-1:0] word_r;

  // Slot update: payload only, no reset
  always_ff @(posedge clk) begin
    unique case (ctl.kind)
      CK_SHR:   word_r <= left_in;
      CK_SHL:   word_r <= right_in;
      CK_WRITE: begin
        if (wr_idx == IDX) begin
          word_r <= ctl.value;
        end
      end
      default:  word_r <= word_r;
    endcase
  end

  assign word_o = word_r;

endmodule

`default_nettype wire

### design/dqc_row.sv
// ----------------------------------------------------------------------------
// dqc_row
// Row of word cells, leftmost word in cell 0, with two select taps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dqc_row
  import dqc_pkg::*;
#(
  parameter int CAPACITY = DQC_CAPACITY,
  parameter int POS_W    = $clog2(CAPACITY)
) (
  input  wire logic                     clk,
  input  wire cell_ctl_t                ctl,
  input  wire logic [POS_W-1:0]         wr_idx,
  input  wire logic [POS_W-1:0]         cur_idx,
  input  wire logic [POS_W-1:0]         last_idx,
  output      logic signed [WORD_W-1:0] first_word,
  output      logic signed [WORD_W-1:0] cur_word,
  output      logic signed [WORD_W-1:0] last_word
);

  logic signed [WORD_W-1:0] w [CAPACITY];

  // Cell chain: each cell sees both neighbours; ends fed by new word / zero
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [WORD_W-1:0] l_in;
    logic signed [WORD_W-1:0] r_in;

    if (i == 0) begin : g_first
      assign l_in = ctl.value;
    end else begin : g_mid_l
      assign l_in = w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_in = '0;
    end else begin : g_mid_r
      assign r_in = w[i+1];
    end

    dqc_cell #(
      .POS_W (POS_W),
      .IDX   (POS_W'(i))
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .wr_idx   (wr_idx),
      .left_in  (l_in),
      .right_in (r_in),
      .word_o   (w[i])
    );
  end

  assign first_word = w[0];

  // Cursor and rightmost taps: and-or select over the row
  always_comb begin
    cur_word  = '0;
    last_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cur_idx == POS_W'(i)) begin
        cur_word = cur_word | w[i];
      end
      if (last_idx == POS_W'(i)) begin
        last_word = last_word | w[i];
      end
    end
  end

endmodule

`default_nettype wire

### design/deque_with_cursor_core.sv
// ----------------------------------------------------------------------------
// deque_with_cursor_core
// Bounded double-ended queue of signed words with a cursor, kept in a
// shifting row of cells with the leftmost word always in cell 0.
// ----------------------------------------------------------------------------
//  channel   dir  beat contents
//  in_ch     in   operation, value
//  out_ch    out  result_value, status, count, is_empty, left/right/cursor word
//
//  One operation at a time: each beat is accepted, then its result is given.
//  The row and the count/cursor registers update on the accept edge; the
//  result beat is shown from the next cycle and held until taken.
//  in_ch.ready is low while a result waits; a stalled result holds all state.
//  Reset clears count and cursor; cell words are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deque_with_cursor_core
  import dqc_pkg::*;
#(
  parameter int CAPACITY = DQC_CAPACITY,
  parameter int POS_W    = $clog2(CAPACITY),
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  wire logic clk,
  input  wire logic rst_n,
  dqc_in_if.sink    in_ch,
  dqc_out_if.source out_ch
);

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [POS_W-1:0]         cpos_r, cpos_nxt;
  logic signed [WORD_W-1:0] res_r, res_nxt;
  status_t                  stat_r, stat_nxt;

  cell_ctl_t                ctl;
  logic [POS_W-1:0]         wr_idx;
  logic [CNT_W-1:0]         cnt_m1;
  logic [POS_W-1:0]         last_idx;
  logic                     empty;
  logic                     full;
  logic                     acc;
  logic signed [WORD_W-1:0] first_word;
  logic signed [WORD_W-1:0] cur_word;
  logic signed [WORD_W-1:0] last_word;

  assign cnt_m1   = cnt_r - CNT_W'(1);
  assign last_idx = cnt_m1[POS_W-1:0];
  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CNT_W'(CAPACITY));
  assign acc      = in_ch.valid && in_ch.ready;

  // Word row
  dqc_row #(
    .CAPACITY (CAPACITY),
    .POS_W    (POS_W)
  ) u_row (
    .clk        (clk),
    .ctl        (ctl),
    .wr_idx     (wr_idx),
    .cur_idx    (cpos_r),
    .last_idx   (last_idx),
    .first_word (first_word),
    .cur_word   (cur_word),
    .last_word  (last_word)
  );

  // Sequencer: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_ch.valid)  state_nxt = S_HOLD;
      S_HOLD:  if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer: handshake outputs
  always_comb begin
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;
    unique case (state_r)
      S_IDLE:  in_ch.ready  = 1'b1;
      S_HOLD:  out_ch.valid = 1'b1;
      default: ;
    endcase
  end

  // Operation decode: row command, count, cursor, result
  always_comb begin
    ctl.kind  = CK_HOLD;
    ctl.value = in_ch.value;
    wr_idx    = cpos_r;
    cnt_nxt   = cnt_r;
    cpos_nxt  = cpos_r;
    res_nxt   = res_r;
    stat_nxt  = stat_r;
    if (acc) begin
      res_nxt  = '0;
      stat_nxt = STAT_OK;
      unique case (op_t'(in_ch.operation))
        OP_PUSH_L: begin
          if (full) begin
            stat_nxt = STAT_FULL;
          end else begin
            ctl.kind = CK_SHR;
            cnt_nxt  = cnt_r + CNT_W'(1);
            cpos_nxt = empty ? '0 : cpos_r + POS_W'(1);
          end
        end
        OP_PUSH_R: begin
          if (full) begin
            stat_nxt = STAT_FULL;
          end else begin
            ctl.kind = CK_WRITE;
            wr_idx   = cnt_r[POS_W-1:0];
            cnt_nxt  = cnt_r + CNT_W'(1);
            if (empty) begin
              cpos_nxt = '0;
            end
          end
        end
        OP_POP_L: begin
          if (empty) begin
            stat_nxt = STAT_EMPTY;
          end else begin
            res_nxt  = first_word;
            ctl.kind = CK_SHL;
            cnt_nxt  = cnt_m1;
            // cursor on the popped word moves inward, which stays at cell 0
            if (cpos_r != '0) begin
              cpos_nxt = cpos_r - POS_W'(1);
            end
          end
        end
        OP_POP_R: begin
          if (empty) begin
            stat_nxt = STAT_EMPTY;
          end else begin
            res_nxt = last_word;
            cnt_nxt = cnt_m1;
            if (cpos_r == last_idx && cpos_r != '0) begin
              cpos_nxt = cpos_r - POS_W'(1);
            end
          end
        end
        OP_CUR_L: begin
          if (empty) begin
            stat_nxt = STAT_EMPTY;
          end else if (cpos_r == '0) begin
            stat_nxt = STAT_AT_END;
          end else begin
            cpos_nxt = cpos_r - POS_W'(1);
          end
        end
        OP_CUR_R: begin
          if (empty) begin
            stat_nxt = STAT_EMPTY;
          end else if (cpos_r == last_idx) begin
            stat_nxt = STAT_AT_END;
          end else begin
            cpos_nxt = cpos_r + POS_W'(1);
          end
        end
        OP_READ: begin
          if (empty) begin
            stat_nxt = STAT_EMPTY;
          end else begin
            res_nxt = cur_word;
          end
        end
        OP_WRITE: begin
          if (empty) begin
            stat_nxt = STAT_EMPTY;
          end else begin
            ctl.kind = CK_WRITE;
            wr_idx   = cpos_r;
          end
        end
        default: ;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      cpos_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      cpos_r  <= cpos_nxt;
    end
  end

  // Result payload registers
  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    stat_r <= stat_nxt;
  end

  // Result beat: words taken from the row after the update
  assign out_ch.result_value = res_r;
  assign out_ch.status       = stat_r;
  assign out_ch.count        = cnt_r;
  assign out_ch.is_empty     = empty;
  assign out_ch.left_word    = empty ? '0 : first_word;
  assign out_ch.right_word   = empty ? '0 : last_word;
  assign out_ch.cursor_word  = empty ? '0 : cur_word;

`ifndef SYNTHESIS
  // Cursor stays on a live word
  a_cursor_live: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (CNT_W'(cpos_r) < cnt_r))
    else $error("cursor outside live words");

  // Count bounded by capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  // Accepted beat is answered next cycle
  a_accept_resp: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_ch.valid)
    else $error("no result after accepted beat");

  // A waiting result freezes the queue
  a_hold_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HOLD && !out_ch.ready) |=>
      (state_r == S_HOLD && $stable(cnt_r) && $stable(cpos_r)))
    else $error("state moved while result waiting");

  // Full status only at capacity
  a_full_stat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && stat_r == STAT_FULL) |-> full)
    else $error("full status below capacity");
`endif

endmodule

`default_nettype wire
